// File: rtl/core/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Used by the front, back, top level and checker; depends on nothing.
package pfa_pkg;

	localparam int FRAME_W        = 6;   // frame number field
	localparam int WORDS_W        = 18;  // word count field
	localparam int PAGE_W         = 13;  // page_words register
	localparam int FCNT_W         = 7;   // frame_count register, holds 0..127
	localparam int NEED_W         = 7;   // frames needed, at most 64
	localparam int LIM_W          = FCNT_W + PAGE_W;
	localparam int NUM_W          = PAGE_W + NEED_W - 1;
	localparam int MAP_W          = 2 ** FRAME_W;
	localparam int GRP_SIZE       = 8;
	localparam int GRP_W          = 3;
	localparam int MAX_FRAMES_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;

	localparam int CFG_W          = PAGE_W;
	localparam int REG_IDX_W      = 2;
	localparam logic [REG_IDX_W-1:0] REG_PAGE_WORDS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

	localparam logic [PAGE_W-1:0] PAGE_WORDS_RST  = 13'd16;
	localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = 7'd64;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REFUSED  = 2'd1;
	localparam logic [1:0] ST_FREE_OOR = 2'd2;

	typedef enum logic [1:0] {
		CMD_REPORT,
		CMD_FREE,
		CMD_ALLOC
	} cmd_op_t;

	typedef struct packed {
		logic               kind;
		logic [WORDS_W-1:0] word_count;
		logic [FRAME_W-1:0] frame_to_free;
		logic               batch_last;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic               frame_valid;
		logic [1:0]         status;
		logic               last;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_op_t            op;
		logic [FRAME_W-1:0] frame;
		logic [1:0]         status;
		logic               last;
		logic [NEED_W-1:0]  need;
	} cmd_t;

endpackage

// File: rtl/core/pfa_fifo.sv
// Small register queue, used between front and back and at the result side.
// Depends on nothing; WIDTH and DEPTH come from the instantiating module.
module pfa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (AW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/pfa_front.sv
// Front end: accepts items, checks ranges and limits, divides the word
// count into frames. Depends on pfa_pkg.
module pfa_front import pfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	input  logic [PAGE_W-1:0] pg,
	input  logic [FCNT_W-1:0] nf,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  logic              cmd_full
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t           state_q;
	cmd_t              cmd_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  den_q;
	logic [NEED_W-1:0] quo_q;
	logic [2:0]        step_q;

	logic [LIM_W-1:0]  limit;
	logic              words_over;
	logic              in_range;
	logic              ge;
	logic [NEED_W-1:0] quo_next;

	assign limit      = LIM_W'(nf) * LIM_W'(pg);
	assign words_over = LIM_W'(item.word_count) > limit;
	assign in_range   = FCNT_W'(item.frame_to_free) < nf;
	// restoring division, one quotient bit per cycle, MSB first
	assign ge         = num_q >= den_q;
	assign quo_next   = {quo_q[NEED_W-2:0], ge};

	assign full     = (state_q != F_IDLE);
	assign cmd_push = (state_q == F_PUSH);
	assign cmd      = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						cmd_q.op     <= CMD_REPORT;
						cmd_q.frame  <= '0;
						cmd_q.status <= ST_OK;
						cmd_q.last   <= item.batch_last;
						cmd_q.need   <= '0;
						state_q      <= F_PUSH;
						if (item.kind == KIND_FREE) begin
							if (in_range) begin
								cmd_q.op    <= CMD_FREE;
								cmd_q.frame <= item.frame_to_free;
							end else begin
								cmd_q.status <= ST_FREE_OOR;
							end
						end else begin
							cmd_q.last <= 1'b1;
							if (words_over) begin
								cmd_q.status <= ST_REFUSED;
							end else if (item.word_count != '0) begin
								cmd_q.op <= CMD_ALLOC;
								num_q    <= NUM_W'(item.word_count) + NUM_W'(pg) - 1'b1;
								den_q    <= {pg, {(NEED_W - 1){1'b0}}};
								quo_q    <= '0;
								step_q   <= '0;
								state_q  <= F_DIV;
							end
						end
					end
				end
				F_DIV: begin
					if (ge) begin
						num_q <= num_q - den_q;
					end
					den_q  <= den_q >> 1;
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (step_q == 3'(NEED_W - 1)) begin
						cmd_q.need <= quo_next;
						state_q    <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!cmd_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/pfa_back.sv
// Back end: owns the free map, counts free frames and claims them first-fit,
// one frame per cycle, stalled on a full result queue. Depends on pfa_pkg.
module pfa_back import pfa_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  cmd_t              cmd,
	input  logic [FCNT_W-1:0] nf,
	output logic              res_push,
	output out_item_t         res,
	input  logic              res_full
);

	localparam int GROUPS = (MAX_FRAMES + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [1:0] {
		B_IDLE,
		B_COUNT,
		B_GRANT,
		B_EMIT
	} bstate_t;

	logic [MAX_FRAMES-1:0] free_q;
	bstate_t               state_q;
	logic [NEED_W-1:0]     need_q;
	logic [GRP_W-1:0]      grp_q;
	logic [FCNT_W-1:0]     avail_q;
	logic [FRAME_W-1:0]    scan_q;
	logic [NEED_W-1:0]     got_q;
	out_item_t             res_q;

	logic [MAP_W-1:0]      map_pad;
	logic [FRAME_W-1:0]    gidx;
	logic [3:0]            grp_cnt;
	logic [FCNT_W-1:0]     avail_next;
	logic                  hit;
	logic                  last_hit;
	logic                  set_en;
	logic                  clr_en;
	out_item_t             grant;

	assign map_pad = MAP_W'(free_q);

	// free frames below nf within the current group of eight
	always_comb begin
		grp_cnt = '0;
		gidx    = '0;
		for (int j = 0; j < GRP_SIZE; j++) begin
			gidx = {grp_q, 3'(j)};
			if (map_pad[gidx] && (FCNT_W'(gidx) < nf)) begin
				grp_cnt = grp_cnt + 1'b1;
			end
		end
	end

	assign avail_next = avail_q + FCNT_W'(grp_cnt);
	assign hit        = map_pad[scan_q];
	assign last_hit   = (NEED_W'(got_q + 1'b1) == need_q);

	assign grant.frame_number = scan_q;
	assign grant.frame_valid  = 1'b1;
	assign grant.status       = ST_OK;
	assign grant.last         = last_hit;

	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
	assign res_push = (state_q == B_EMIT) || ((state_q == B_GRANT) && hit);
	assign res      = (state_q == B_GRANT) ? grant : res_q;

	assign set_en = cmd_pop && (cmd.op == CMD_FREE);
	assign clr_en = (state_q == B_GRANT) && hit && !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (set_en && (cmd.frame == FRAME_W'(i))) begin
					free_q[i] <= 1'b1;
				end
				if (clr_en && (scan_q == FRAME_W'(i))) begin
					free_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			grp_q   <= '0;
			scan_q  <= '0;
			got_q   <= '0;
			avail_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						need_q             <= cmd.need;
						res_q.frame_number <= cmd.frame;
						res_q.frame_valid  <= (cmd.op == CMD_FREE);
						res_q.status       <= cmd.status;
						res_q.last         <= cmd.last;
						if (cmd.op == CMD_ALLOC) begin
							grp_q   <= '0;
							avail_q <= '0;
							state_q <= B_COUNT;
						end else begin
							state_q <= B_EMIT;
						end
					end
				end
				B_COUNT: begin
					avail_q <= avail_next;
					grp_q   <= grp_q + 1'b1;
					if (grp_q == GRP_W'(GROUPS - 1)) begin
						if (FCNT_W'(need_q) > avail_next) begin
							res_q.frame_number <= '0;
							res_q.frame_valid  <= 1'b0;
							res_q.status       <= ST_REFUSED;
							res_q.last         <= 1'b1;
							state_q            <= B_EMIT;
						end else begin
							scan_q  <= '0;
							got_q   <= '0;
							state_q <= B_GRANT;
						end
					end
				end
				B_GRANT: begin
					// enough free frames exist below nf, so the scan stops in range
					if (hit) begin
						if (!res_full) begin
							got_q  <= got_q + 1'b1;
							scan_q <= scan_q + 1'b1;
							if (last_hit) begin
								state_q <= B_IDLE;
							end
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				B_EMIT: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/page_frame_allocator.sv
// First-fit page frame allocator. The front holds one item at a time, taking
// the next once the last is in the command queue. An alloc runs the front's
// 7-step divider, then a back-end scan of one frame per cycle, stalled on a
// full result queue, to the highest granted frame; the scan bounds throughput.
// Reset: all frames free, page_words 16, frame_count 64, both queues empty.
module page_frame_allocator import pfa_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_item_t             item,
	output logic                 empty,
	input  logic                 pop,
	output out_item_t            result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	logic [PAGE_W-1:0] page_words_q;
	logic [FCNT_W-1:0] frame_count_q;
	logic [PAGE_W-1:0] pg;
	logic [FCNT_W-1:0] nf;

	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_empty;
	logic              cmd_pop;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic              res_push;
	logic              res_full;
	out_item_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_words_q  <= PAGE_WORDS_RST;
			frame_count_q <= FRAME_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_PAGE_WORDS:  page_words_q  <= wr_data;
				REG_FRAME_COUNT: frame_count_q <= wr_data[FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign pg = (page_words_q == '0) ? PAGE_W'(1) : page_words_q;
	assign nf = (frame_count_q == '0) ? FCNT_W'(1) :
	            (frame_count_q > FCNT_W'(MAX_FRAMES)) ? FCNT_W'(MAX_FRAMES) : frame_count_q;

	pfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.pg       (pg),
		.nf       (nf),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	pfa_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.dout   (cmd_out)
	);

	pfa_back #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_out),
		.nf        (nf),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	pfa_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule

// File: rtl/core/pfa_checker.sv
// Port-level checks on the allocator's result side, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator.
module pfa_checker import pfa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// a granted or released frame is always reported ok
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_valid |-> result.status == ST_OK)
		else $error("frame carried with non-ok status");

	// a result without a frame reports frame zero
	a_novalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.frame_valid |-> result.frame_number == '0)
		else $error("frame number set on a result without a frame");

	// a refusal ends its item and carries no frame
	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_REFUSED |-> result.last && !result.frame_valid)
		else $error("malformed refusal");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
